[rtl/core/bme_pkg.sv]
// Package for the bipartite matching engine: sizes, payload types, codes,
// datapath micro-operations and the controller/datapath status structs.
// No dependencies.
package bme_pkg;

    localparam int MAX_PEOPLE = 64;
    localparam int MAX_ROLES  = 64;
    localparam int MAX_DEGREE = 16;

    localparam int IDX_W = 6;   // person_index / role_index field width
    localparam int CNT_W = 7;   // count register and match_count width
    localparam int CMP_W = 12;  // common width for index versus count compares

    localparam int PW      = $clog2(MAX_PEOPLE);
    localparam int RW      = $clog2(MAX_ROLES);
    localparam int DW      = $clog2(MAX_DEGREE + 1);
    localparam int ADJ_N   = MAX_PEOPLE * MAX_DEGREE;
    localparam int AW      = $clog2(ADJ_N);
    localparam int SPW     = $clog2(MAX_PEOPLE);
    localparam int ROOT_W  = PW + 1;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_GREEDY = 2'd1;
    localparam logic [1:0] CMD_EXACT  = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_RANGE = 2'd2;

    localparam logic REG_PERSON_COUNT = 1'b0;
    localparam logic REG_ROLE_COUNT   = 1'b1;

    typedef logic [PW-1:0]     t_pid;
    typedef logic [RW-1:0]     t_rid;
    typedef logic [DW-1:0]     t_pos;
    typedef logic [AW-1:0]     t_adj_addr;
    typedef logic [SPW-1:0]    t_sp;
    typedef logic [ROOT_W-1:0] t_root;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [CMP_W-1:0]  t_cmp;

    typedef struct packed {
        logic [1:0]       command;
        logic [IDX_W-1:0] person_index;
        logic [IDX_W-1:0] role_index;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] match_count;
        logic [1:0]       status;
    } t_out_item;

    // One search frame held on the stack.
    typedef struct packed {
        t_pid person;
        t_pos pos;
        t_rid role;
        t_pos deg;
    } t_frame;

    typedef enum logic [3:0] {
        U_NOP,
        U_EDGE_RD,
        U_EDGE_WR,
        U_SOLVE_INIT,
        U_ROOT_START,
        U_LOAD_DEG,
        U_FETCH,
        U_GREEDY_TAKE,
        U_MARK,
        U_CLAIM,
        U_PUSH,
        U_POP_RD,
        U_POP_LD,
        U_UNW_RD,
        U_UNW_WR,
        U_NEXT_ROOT
    } t_uop;

    typedef struct packed {
        logic in_range;
        logic deg_full;
        logic root_done;
        logic pos_done;
        logic sp_zero;
        logic sp_one;
        logic cand_greedy;
        logic cand_exact;
        logic owner_free;
        logic can_push;
    } t_dp_stat;

    typedef struct packed {
        logic       load;
        logic [1:0] status;
        logic       use_count;
    } t_resp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_INIT,
        ST_ROOT,
        ST_DEG,
        ST_STEP,
        ST_ADJ,
        ST_OWN,
        ST_POP,
        ST_UNW_RD,
        ST_UNW_WR,
        ST_NEXT,
        ST_RESP
    } t_state;

    function automatic t_cmp eff_count(input t_cnt cnt, input int max_n);
        return (t_cmp'(cnt) > t_cmp'(max_n)) ? t_cmp'(max_n) : t_cmp'(cnt);
    endfunction

endpackage

[rtl/core/bme_dp.sv]
// Datapath of the matching engine: adjacency, degree, owner and stack
// memories, scratch flags and search registers. Depends on bme_pkg.
module bme_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bme_pkg::t_uop               i_uop,
    input  logic [bme_pkg::IDX_W-1:0]   i_person,
    input  logic [bme_pkg::IDX_W-1:0]   i_role,
    input  bme_pkg::t_cnt               i_person_count,
    input  bme_pkg::t_cnt               i_role_count,
    output bme_pkg::t_dp_stat           o_stat,
    output bme_pkg::t_cnt               o_total
);
    import bme_pkg::*;

    t_rid   mem_adj [ADJ_N];
    t_pos   mem_deg [MAX_PEOPLE];
    t_pid   mem_own [MAX_ROLES];
    t_frame mem_stk [MAX_PEOPLE];

    t_rid   r_adj_q;
    t_pos   r_deg_q;
    logic   r_deg_v;
    t_pid   r_own_q;
    logic   r_own_v;
    t_frame r_stk_q;

    logic [MAX_PEOPLE-1:0] r_deg_valid;
    logic [MAX_ROLES-1:0]  r_own_valid;
    logic [MAX_ROLES-1:0]  r_visited;
    logic [MAX_ROLES-1:0]  r_taken;

    t_pid  r_e_p;
    t_rid  r_e_r;
    t_pid  r_cur_p;
    t_pos  r_pos;
    t_pos  r_deg;
    t_rid  r_cur_role;
    t_rid  r_role;
    t_root r_root;
    t_sp   r_sp;
    t_cnt  r_total;

    t_cmp np, nr;
    t_pos deg_eff;
    t_pid deg_addr;
    t_sp  sp_dec;

    assign np      = eff_count(i_person_count, MAX_PEOPLE);
    assign nr      = eff_count(i_role_count, MAX_ROLES);
    assign deg_eff = r_deg_v ? r_deg_q : '0;
    assign sp_dec  = r_sp - t_sp'(1);

    always_comb begin
        case (i_uop)
            U_EDGE_RD: deg_addr = t_pid'(i_person);
            U_PUSH:    deg_addr = r_own_q;
            default:   deg_addr = t_pid'(r_root);
        endcase
    end

    // Degree memory with per-entry valid bits.
    always_ff @(posedge i_clk) begin
        if (i_uop == U_EDGE_WR) begin
            mem_deg[r_e_p] <= deg_eff + t_pos'(1);
        end
        if (i_uop == U_EDGE_RD || i_uop == U_ROOT_START || i_uop == U_PUSH) begin
            r_deg_q <= mem_deg[deg_addr];
            r_deg_v <= r_deg_valid[deg_addr];
        end
    end

    // Adjacency memory.
    always_ff @(posedge i_clk) begin
        if (i_uop == U_EDGE_WR) begin
            mem_adj[t_adj_addr'(r_e_p) * t_adj_addr'(MAX_DEGREE) + t_adj_addr'(deg_eff)]
                <= r_e_r;
        end
        if (i_uop == U_FETCH) begin
            r_adj_q <= mem_adj[t_adj_addr'(r_cur_p) * t_adj_addr'(MAX_DEGREE)
                               + t_adj_addr'(r_pos)];
        end
    end

    // Role owner memory.
    always_ff @(posedge i_clk) begin
        if (i_uop == U_CLAIM) begin
            mem_own[r_role] <= r_cur_p;
        end else if (i_uop == U_UNW_WR) begin
            mem_own[r_cur_role] <= r_stk_q.person;
        end
        if (i_uop == U_MARK) begin
            r_own_q <= mem_own[r_adj_q];
            r_own_v <= r_own_valid[r_adj_q];
        end
    end

    // Search stack memory.
    always_ff @(posedge i_clk) begin
        if (i_uop == U_PUSH) begin
            mem_stk[r_sp] <= '{person: r_cur_p, pos: r_pos, role: r_cur_role, deg: r_deg};
        end
        if (i_uop == U_POP_RD || i_uop == U_UNW_RD) begin
            r_stk_q <= mem_stk[sp_dec];
        end
    end

    // Valid and scratch flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_valid <= '0;
            r_own_valid <= '0;
            r_visited   <= '0;
            r_taken     <= '0;
        end else begin
            case (i_uop)
                U_EDGE_WR:     r_deg_valid[r_e_p] <= 1'b1;
                U_SOLVE_INIT: begin
                    r_own_valid <= '0;
                    r_taken     <= '0;
                end
                U_ROOT_START:  r_visited <= '0;
                U_GREEDY_TAKE: r_taken[r_adj_q] <= 1'b1;
                U_MARK:        r_visited[r_adj_q] <= 1'b1;
                U_CLAIM:       r_own_valid[r_role] <= 1'b1;
                default: ;
            endcase
        end
    end

    // Search registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_root  <= '0;
            r_total <= '0;
        end else begin
            case (i_uop)
                U_EDGE_RD: begin
                    r_e_p <= t_pid'(i_person);
                    r_e_r <= t_rid'(i_role);
                end
                U_SOLVE_INIT: begin
                    r_total <= '0;
                    r_root  <= '0;
                end
                U_ROOT_START: begin
                    r_cur_p    <= t_pid'(r_root);
                    r_pos      <= '0;
                    r_cur_role <= '0;
                    r_sp       <= '0;
                end
                U_LOAD_DEG: r_deg <= deg_eff;
                U_FETCH:    r_pos <= r_pos + t_pos'(1);
                U_GREEDY_TAKE: begin
                    r_total <= r_total + t_cnt'(1);
                    r_root  <= r_root + t_root'(1);
                end
                U_MARK:  r_role  <= r_adj_q;
                U_CLAIM: r_total <= r_total + t_cnt'(1);
                U_PUSH: begin
                    r_sp       <= r_sp + t_sp'(1);
                    r_cur_p    <= r_own_q;
                    r_pos      <= '0;
                    r_cur_role <= r_role;
                end
                U_POP_RD: r_sp <= sp_dec;
                U_POP_LD: begin
                    r_cur_p    <= r_stk_q.person;
                    r_pos      <= r_stk_q.pos;
                    r_cur_role <= r_stk_q.role;
                    r_deg      <= r_stk_q.deg;
                end
                U_UNW_WR: begin
                    r_cur_role <= r_stk_q.role;
                    r_sp       <= sp_dec;
                end
                U_NEXT_ROOT: r_root <= r_root + t_root'(1);
                default: ;
            endcase
        end
    end

    assign o_stat.in_range    = (t_cmp'(r_e_p) < np) && (t_cmp'(r_e_r) < nr);
    assign o_stat.deg_full    = deg_eff >= t_pos'(MAX_DEGREE);
    assign o_stat.root_done   = t_cmp'(r_root) >= np;
    assign o_stat.pos_done    = r_pos >= r_deg;
    assign o_stat.sp_zero     = r_sp == '0;
    assign o_stat.sp_one      = r_sp == t_sp'(1);
    assign o_stat.cand_greedy = (t_cmp'(r_adj_q) < nr) && !r_taken[r_adj_q];
    assign o_stat.cand_exact  = (t_cmp'(r_adj_q) < nr) && !r_visited[r_adj_q];
    assign o_stat.owner_free  = !r_own_v;
    assign o_stat.can_push    = r_sp < t_sp'(MAX_PEOPLE - 1);
    assign o_total            = r_total;

endmodule

[rtl/core/bme_ctrl.sv]
// Controller state machine of the matching engine: sequences edge loads,
// greedy and augmenting-path solves over the datapath. Depends on bme_pkg.
module bme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_command,
    output logic              o_in_ready,
    input  bme_pkg::t_dp_stat i_stat,
    input  logic              i_out_free,
    output bme_pkg::t_uop     o_uop,
    output bme_pkg::t_resp    o_resp
);
    import bme_pkg::*;

    t_state     r_state, n_state;
    logic       r_exact, n_exact;
    logic [1:0] r_status, n_status;
    logic       r_use_count, n_use_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_exact     <= 1'b0;
            r_status    <= STS_OK;
            r_use_count <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exact     <= n_exact;
            r_status    <= n_status;
            r_use_count <= n_use_count;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_exact     = r_exact;
        n_status    = r_status;
        n_use_count = r_use_count;
        o_uop       = U_NOP;
        o_resp      = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_use_count = 1'b0;
                    n_status    = STS_OK;
                    case (i_command)
                        CMD_ADD: begin
                            o_uop   = U_EDGE_RD;
                            n_state = ST_EDGE;
                        end
                        CMD_GREEDY: begin
                            n_exact = 1'b0;
                            n_state = ST_INIT;
                        end
                        CMD_EXACT: begin
                            n_exact = 1'b1;
                            n_state = ST_INIT;
                        end
                        default: begin
                            n_status = STS_RANGE;
                            n_state  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_EDGE: begin
                if (!i_stat.in_range) begin
                    n_status = STS_RANGE;
                end else if (i_stat.deg_full) begin
                    n_status = STS_FULL;
                end else begin
                    o_uop = U_EDGE_WR;
                end
                n_state = ST_RESP;
            end
            ST_INIT: begin
                o_uop   = U_SOLVE_INIT;
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (i_stat.root_done) begin
                    n_use_count = 1'b1;
                    n_state     = ST_RESP;
                end else begin
                    o_uop   = U_ROOT_START;
                    n_state = ST_DEG;
                end
            end
            ST_DEG: begin
                o_uop   = U_LOAD_DEG;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (!i_stat.pos_done) begin
                    o_uop   = U_FETCH;
                    n_state = ST_ADJ;
                end else if (!r_exact || i_stat.sp_zero) begin
                    n_state = ST_NEXT;
                end else begin
                    o_uop   = U_POP_RD;
                    n_state = ST_POP;
                end
            end
            ST_ADJ: begin
                if (!r_exact) begin
                    if (i_stat.cand_greedy) begin
                        o_uop   = U_GREEDY_TAKE;
                        n_state = ST_ROOT;
                    end else begin
                        n_state = ST_STEP;
                    end
                end else if (i_stat.cand_exact) begin
                    o_uop   = U_MARK;
                    n_state = ST_OWN;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_OWN: begin
                if (i_stat.owner_free) begin
                    o_uop   = U_CLAIM;
                    n_state = i_stat.sp_zero ? ST_NEXT : ST_UNW_RD;
                end else if (i_stat.can_push) begin
                    o_uop   = U_PUSH;
                    n_state = ST_DEG;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_POP: begin
                o_uop   = U_POP_LD;
                n_state = ST_STEP;
            end
            ST_UNW_RD: begin
                o_uop   = U_UNW_RD;
                n_state = ST_UNW_WR;
            end
            ST_UNW_WR: begin
                o_uop   = U_UNW_WR;
                n_state = i_stat.sp_one ? ST_NEXT : ST_UNW_RD;
            end
            ST_NEXT: begin
                o_uop   = U_NEXT_ROOT;
                n_state = ST_ROOT;
            end
            ST_RESP: begin
                if (i_out_free) begin
                    o_resp.load      = 1'b1;
                    o_resp.status    = r_status;
                    o_resp.use_count = r_use_count;
                    n_state          = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/core/bipartite_matching_engine.sv]
// Bipartite matching engine. An add-edge item passes through the edge check
// state and then the response state; a solve steps through each visited list
// entry and each stack push, pop and unwind step of the search, bounded by the edges.
// One item is worked on at a time; the next is taken once the result is in
// the output register. Reset is synchronous and active low; it sets both
// counts to 64 and empties every adjacency list at once; no clearing pass.
module bipartite_matching_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bme_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bme_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bme_pkg::*;

    // Configuration registers: user writes only while engine is idle; not enforced.
    t_cnt r_person_count;
    t_cnt r_role_count;

    t_dp_stat  dp_stat;
    t_uop      uop;
    t_resp     resp;
    t_cnt      total;
    logic      out_free;
    logic      r_out_valid;
    t_out_item r_out_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_person_count <= t_cnt'(64);
            r_role_count   <= t_cnt'(64);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_PERSON_COUNT: r_person_count <= pwdata[CNT_W-1:0];
                REG_ROLE_COUNT:   r_role_count   <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PERSON_COUNT: prdata = 32'(r_person_count);
            REG_ROLE_COUNT:   prdata = 32'(r_role_count);
            default:          prdata = '0;
        endcase
    end

    // The output register frees itself when the current result is taken,
    // so a new result may be loaded in the same cycle.
    assign out_free = !r_out_valid || i_out_ready;

    bme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_item.command),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .i_out_free (out_free),
        .o_uop      (uop),
        .o_resp     (resp)
    );

    bme_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uop          (uop),
        .i_person       (i_in_item.person_index),
        .i_role         (i_in_item.role_index),
        .i_person_count (r_person_count),
        .i_role_count   (r_role_count),
        .o_stat         (dp_stat),
        .o_total        (total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resp.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp.load) begin
            r_out_item.match_count <= resp.use_count ? total : '0;
            r_out_item.status      <= resp.status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[verif/bipartite_matching_engine_tb.sv]
// Self-checking testbench for the bipartite matching engine.
// Depends on bme_pkg and bipartite_matching_engine; a scoreboard class
// predicts each result and plain tasks drive the item and APB ports.
`timescale 1ns / 1ps

module bipartite_matching_engine_tb;
    import bme_pkg::*;

    // Predicts match counts and status codes from its own copy of the edge
    // lists and counts, and holds the expected results in arrival order.
    class matching_scoreboard;
        logic [5:0]  adj_role[MAX_PEOPLE][MAX_DEGREE];
        int          degree[MAX_PEOPLE];
        int          person_cnt;
        int          role_cnt;
        t_out_item   expected_q[$];
        int          errors;
        int          results_seen;

        function new();
            for (int p = 0; p < MAX_PEOPLE; p++) degree[p] = 0;
            person_cnt   = 64;
            role_cnt     = 64;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_count(int idx, int value);
            if (idx == 0) person_cnt = value & 8'h7F;
            else role_cnt = value & 8'h7F;
        endfunction

        function int live_people();
            return (person_cnt > MAX_PEOPLE) ? MAX_PEOPLE : person_cnt;
        endfunction

        function int live_roles();
            return (role_cnt > MAX_ROLES) ? MAX_ROLES : role_cnt;
        endfunction

        // Persons in ascending order each take the first free listed role.
        function int greedy_matches();
            bit taken[MAX_ROLES];
            int total;
            int r;
            total = 0;
            for (int i = 0; i < MAX_ROLES; i++) taken[i] = 0;
            for (int p = 0; p < live_people(); p++) begin
                for (int k = 0; k < degree[p]; k++) begin
                    r = adj_role[p][k];
                    if (r < live_roles() && !taken[r]) begin
                        taken[r] = 1;
                        total++;
                        break;
                    end
                end
            end
            return total;
        endfunction

        // Kuhn's search with an explicit frame stack, one root at a time.
        function int exact_matches();
            int owner[MAX_ROLES];
            bit visited[MAX_ROLES];
            int fr_person[MAX_PEOPLE];
            int fr_pos[MAX_PEOPLE];
            int fr_role[MAX_PEOPLE];
            int depth, top, p, r, own, total;
            bit found;
            total = 0;
            for (int i = 0; i < MAX_ROLES; i++) owner[i] = MAX_PEOPLE;
            for (int root = 0; root < live_people(); root++) begin
                for (int i = 0; i < MAX_ROLES; i++) visited[i] = 0;
                fr_person[0] = root;
                fr_pos[0]    = 0;
                fr_role[0]   = 0;
                depth        = 1;
                found        = 0;
                while (depth > 0 && !found) begin
                    top = depth - 1;
                    p   = fr_person[top];
                    if (fr_pos[top] >= degree[p]) begin
                        depth--;
                        continue;
                    end
                    r = adj_role[p][fr_pos[top]];
                    fr_pos[top]++;
                    if (r >= live_roles() || visited[r]) continue;
                    visited[r] = 1;
                    own = owner[r];
                    if (own >= MAX_PEOPLE) begin
                        // Free role: flip the ownership along the path.
                        owner[r] = p;
                        for (int d = top; d > 0; d--)
                            owner[fr_role[d]] = fr_person[d-1];
                        found = 1;
                    end else if (depth < MAX_PEOPLE) begin
                        fr_person[depth] = own;
                        fr_pos[depth]    = 0;
                        fr_role[depth]   = r;
                        depth++;
                    end
                end
                if (found) total++;
            end
            return total;
        endfunction

        function void note_item(t_in_item it);
            t_out_item res;
            int p, r;
            res = '0;
            p = it.person_index;
            r = it.role_index;
            if (it.command == CMD_ADD) begin
                if (p >= live_people() || r >= live_roles()) begin
                    res.status = STS_RANGE;
                end else if (degree[p] >= MAX_DEGREE) begin
                    res.status = STS_FULL;
                end else begin
                    adj_role[p][degree[p]] = it.role_index;
                    degree[p]++;
                    res.status = STS_OK;
                end
            end else if (it.command == CMD_GREEDY) begin
                res.match_count = CNT_W'(greedy_matches());
                res.status      = STS_OK;
            end else if (it.command == CMD_EXACT) begin
                res.match_count = CNT_W'(exact_matches());
                res.status      = STS_OK;
            end else begin
                res.status = STS_RANGE;
            end
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result match_count=%0d status=%0d",
                         $realtime, got.match_count, got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.match_count !== want.match_count) begin
                $display("%0t: match_count mismatch expected=%0d actual=%0d",
                         $realtime, want.match_count, got.match_count);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $realtime, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    matching_scoreboard sb;
    int items_sent;
    int solves_sent;
    int settings_used;
    // When set, the receiver keeps ready high so results drain back to back.
    bit sink_always_ready;

    bipartite_matching_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Results are taken whenever valid and ready meet at a clock edge. The
    // output ready sampled here is the value from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_item);
    end

    // Receiver back pressure: random stretches of stall and of readiness.
    initial begin
        int hold;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (sink_always_ready) begin
                i_out_ready <= 1'b1;
            end else begin
                hold = pick_gap();
                if (hold == 0) begin
                    i_out_ready <= 1'b1;
                    repeat ($urandom_range(0, 12)) @(posedge i_clk);
                end else begin
                    i_out_ready <= 1'b0;
                    repeat (hold - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Offers one item and returns at the edge that accepts it. Valid is
    // only lowered when a gap comes first, so it never toggles in one step.
    task automatic send_item(t_in_item it, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        items_sent++;
        if (it.command == CMD_GREEDY || it.command == CMD_EXACT) solves_sent++;
    endtask

    task automatic send_fields(logic [1:0] cmd, int p, int r);
        t_in_item it;
        it.command      = cmd;
        it.person_index = IDX_W'(p);
        it.role_index   = IDX_W'(r);
        send_item(it, pick_gap());
    endtask

    // Holds the sender back until every expected result has come in.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the access edge since pready is always high. The bus then
    // goes idle before the next transfer.
    task automatic write_count(int idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_count(idx, value);
        @(posedge i_clk);
    endtask

    task automatic set_counts(int people, int roles);
        drain_results();
        write_count(int'(REG_PERSON_COUNT), people);
        write_count(int'(REG_ROLE_COUNT), roles);
        settings_used++;
    endtask

    // Random phase: mostly in-range edge loads, some solves, a little noise.
    // Exact solves on wide graphs are slow, so those are kept rare.
    task automatic random_phase(int people, int roles, int n);
        int roll, lp, lr, exact_left;
        set_counts(people, roles);
        lp = sb.live_people();
        lr = sb.live_roles();
        exact_left = (lp > 16) ? 3 : 1000;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            sink_always_ready = ($urandom_range(0, 9) == 0);
            if (roll < 5) begin
                send_fields(CMD_GREEDY, $urandom_range(0, 63), $urandom_range(0, 63));
            end else if (roll < 9 && exact_left > 0) begin
                exact_left--;
                send_fields(CMD_EXACT, $urandom_range(0, 63), $urandom_range(0, 63));
            end else if (roll < 16) begin
                // Noise: any command code and any index bits.
                send_fields(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                            $urandom_range(0, 63));
            end else if (lp == 0 || lr == 0) begin
                send_fields(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
            end else begin
                send_fields(CMD_ADD, $urandom_range(0, lp - 1), $urandom_range(0, lr - 1));
            end
            // Once mid-phase, let the block run empty before going on.
            if (k == n / 2) drain_results();
        end
        sink_always_ready = 0;
    endtask

    initial begin
        sb = new();
        items_sent = 0;
        solves_sent = 0;
        settings_used = 0;
        sink_always_ready = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset counts: duplicates, both solve modes,
        // the unknown command, the corner indices and a full list.
        send_fields(CMD_ADD, 0, 0);
        send_fields(CMD_ADD, 0, 1);
        send_fields(CMD_ADD, 1, 0);
        send_fields(CMD_ADD, 0, 0);
        send_fields(CMD_GREEDY, 0, 0);
        send_fields(CMD_EXACT, 63, 63);
        send_fields(2'd3, 63, 63);
        send_fields(CMD_ADD, 63, 63);
        for (int k = 0; k <= MAX_DEGREE; k++) send_fields(CMD_ADD, 5, k);
        send_fields(CMD_EXACT, 0, 0);

        // Zero counts reject every edge and solve to nothing.
        set_counts(0, 0);
        send_fields(CMD_ADD, 0, 0);
        send_fields(CMD_GREEDY, 0, 0);
        send_fields(CMD_EXACT, 0, 0);
        // Shrunk counts: lists loaded above are partly out of range now.
        set_counts(1, 1);
        send_fields(CMD_ADD, 1, 0);
        send_fields(CMD_ADD, 0, 1);
        send_fields(CMD_GREEDY, 0, 0);
        send_fields(CMD_EXACT, 0, 0);
        // Counts above the array size act as the array size.
        set_counts(127, 127);
        send_fields(CMD_ADD, 63, 0);
        send_fields(CMD_EXACT, 0, 0);

        random_phase(8, 8, 200);
        random_phase(1, 1, 40);
        random_phase(16, 64, 250);
        random_phase(64, 16, 250);
        random_phase(2, 64, 60);
        random_phase(32, 40, 150);
        random_phase(64, 64, 400);
        random_phase(64, 1, 60);
        random_phase(127, 127, 60);

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d items (%0d solves) over %0d count settings; %0d results checked.",
                 items_sent, solves_sent, settings_used, sb.results_seen);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #1s;
        $display("Timeout with %0d results still expected.", sb.expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
